@@ src/srsf_pkg.sv @@
// Shared types, codes and constants of the sumo strategy machine.
package srsf_pkg;

  // Strategy modes, one-hot. The bit position is the reported mode code.
  typedef enum logic [12:0] {
    MODE_LAUNCH   = 13'b0_0000_0000_0001,
    MODE_START    = 13'b0_0000_0000_0010,
    MODE_SEARCH   = 13'b0_0000_0000_0100,
    MODE_ALIGN    = 13'b0_0000_0000_1000,
    MODE_ORBIT    = 13'b0_0000_0001_0000,
    MODE_ADVANCE  = 13'b0_0000_0010_0000,
    MODE_LOW      = 13'b0_0000_0100_0000,
    MODE_HIGH     = 13'b0_0000_1000_0000,
    MODE_LINE     = 13'b0_0001_0000_0000,
    MODE_REVERSE  = 13'b0_0010_0000_0000,
    MODE_PIVOT    = 13'b0_0100_0000_0000,
    MODE_RIGHT180 = 13'b0_1000_0000_0000,
    MODE_LEFT180  = 13'b1_0000_0000_0000
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_BOTH  = 3'd1,
    ACT_FWD   = 3'd2,
    ACT_BACK  = 3'd3,
    ACT_LEFT  = 3'd4,
    ACT_RIGHT = 3'd5,
    ACT_PIVOT = 3'd6,
    ACT_STOP  = 3'd7
  } action_e;

  // Register indexes.
  localparam logic [2:0] REG_LAUNCH_MS   = 3'd0;
  localparam logic [2:0] REG_LOW_MS      = 3'd1;
  localparam logic [2:0] REG_HIGH_MS     = 3'd2;
  localparam logic [2:0] REG_REVERSE_MS  = 3'd3;
  localparam logic [2:0] REG_PIVOT_MS    = 3'd4;
  localparam logic [2:0] REG_HALF_TURN   = 3'd5;
  localparam logic [2:0] REG_POWER_A     = 3'd6;
  localparam logic [2:0] REG_POWER_B     = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [7:0]        STOP_LINE = 8'd60;
  localparam logic [7:0]        STOP_TURN = 8'd100;
  localparam logic signed [7:0] ORBIT_LS  = -8'sd10;
  localparam logic signed [7:0] ORBIT_RS  = 8'sd5;

  typedef struct packed {
    logic [15:0] launch_ms;
    logic [15:0] low_attack_ms;
    logic [15:0] high_attack_ms;
    logic [15:0] reverse_ms;
    logic [15:0] attack_pivot_ms;
    logic [15:0] half_turn_ms;
    logic [31:0] power_set_a;
    logic [39:0] power_set_b;
  } cfg_t;

  // Which time stamps take the current time on this request.
  typedef struct packed {
    logic low;
    logic high;
    logic turn;
    logic pivot;
    logic rev;
  } stamp_ld_t;

  typedef struct packed {
    logic [15:0]       hold_ms;
    logic [7:0]        stop_arg;
    logic signed [7:0] right_speed;
    logic signed [7:0] left_speed;
    logic [7:0]        drive_power;
    action_e           drive_action;
    logic [3:0]        mode_now;
  } res_t;

  function automatic logic [3:0] mode_code(mode_e m);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 13; i++) begin
      if (m[i]) begin
        c = 4'(i);
      end
    end
    return c;
  endfunction

endpackage

@@ src/sumo_robot_strategy_fsm_core.sv @@
// Top level of the sumo strategy machine: registers, handshakes, result stage.
//
//  Channel  Dir  Handshake                     Payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: now, enemy, line; tuser: cmd
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: mode, action, power, speeds,
//                                              stop arg, hold
//  cfg      in   cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// One request per cycle while no result is stalled: the result register is loaded
// as the request is accepted; the mode logic is a single pass from the state
// registers to the result register. A new request is taken while the held
// result is being taken. Input is stalled only while a result waits and
// m_axis_tready is low. Reset (rst_ni low, asynchronous) puts the machine in
// launch mode, clears all time stamps and loads the register defaults.
module sumo_robot_strategy_fsm_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] now_ms, [38:32] enemy_sensors, [40:39] line_sensors, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  // result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] mode_now, [6:4] drive_action, [14:7] drive_power, [22:15] left_speed,
  // [30:23] right_speed, [38:31] stop_arg, [54:39] hold_ms, [55] zero
  output logic [55:0] m_axis_tdata,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [srsf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [srsf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  srsf_pkg::cfg_t       cfg_q;
  srsf_pkg::mode_e      mode_q, mode_d;
  srsf_pkg::stamp_ld_t  ld;
  srsf_pkg::res_t       res_d, res_q;
  logic                 out_valid_q;
  logic [TIME_BITS-1:0] low_start_q, high_start_q, turn_start_q;
  logic [TIME_BITS-1:0] pivot_start_q, rev_start_q;
  logic [TIME_BITS+31:0] now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic                 in_acc;

  // Time stamp is taken modulo 2^TIME_BITS.
  assign now_ext = {{TIME_BITS{1'b0}}, s_axis_tdata[31:0]};
  assign now_t   = now_ext[TIME_BITS-1:0];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.launch_ms       <= 16'd200;
      cfg_q.low_attack_ms   <= 16'd300;
      cfg_q.high_attack_ms  <= 16'd300;
      cfg_q.reverse_ms      <= 16'd300;
      cfg_q.attack_pivot_ms <= 16'd150;
      cfg_q.half_turn_ms    <= 16'd400;
      cfg_q.power_set_a     <= '0;
      cfg_q.power_set_b     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srsf_pkg::REG_LAUNCH_MS:  cfg_q.launch_ms       <= cfg_data_i[15:0];
        srsf_pkg::REG_LOW_MS:     cfg_q.low_attack_ms   <= cfg_data_i[15:0];
        srsf_pkg::REG_HIGH_MS:    cfg_q.high_attack_ms  <= cfg_data_i[15:0];
        srsf_pkg::REG_REVERSE_MS: cfg_q.reverse_ms      <= cfg_data_i[15:0];
        srsf_pkg::REG_PIVOT_MS:   cfg_q.attack_pivot_ms <= cfg_data_i[15:0];
        srsf_pkg::REG_HALF_TURN:  cfg_q.half_turn_ms    <= cfg_data_i[15:0];
        srsf_pkg::REG_POWER_A:    cfg_q.power_set_a     <= cfg_data_i[31:0];
        srsf_pkg::REG_POWER_B:    cfg_q.power_set_b     <= cfg_data_i[39:0];
        default: begin
        end
      endcase
    end
  end

  srsf_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cmd_i         (s_axis_tuser),
    .now_i         (now_t),
    .enemy_i       (s_axis_tdata[38:32]),
    .line_i        (s_axis_tdata[40:39]),
    .mode_i        (mode_q),
    .cfg_i         (cfg_q),
    .low_start_i   (low_start_q),
    .high_start_i  (high_start_q),
    .turn_start_i  (turn_start_q),
    .pivot_start_i (pivot_start_q),
    .rev_start_i   (rev_start_q),
    .mode_o        (mode_d),
    .ld_o          (ld),
    .res_o         (res_d)
  );

  // Mode, stamps and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= srsf_pkg::MODE_LAUNCH;
      low_start_q   <= '0;
      high_start_q  <= '0;
      turn_start_q  <= '0;
      pivot_start_q <= '0;
      rev_start_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q <= mode_d;
        if (ld.low)   low_start_q   <= now_t;
        if (ld.high)  high_start_q  <= now_t;
        if (ld.turn)  turn_start_q  <= now_t;
        if (ld.pivot) pivot_start_q <= now_t;
        if (ld.rev)   rev_start_q   <= now_t;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

`ifndef SYNTHESIS
  // A stop request lands in launch mode with a line-type stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser |=> m_axis_tvalid &&
      res_q.drive_action == srsf_pkg::ACT_STOP &&
      res_q.mode_now == srsf_pkg::mode_code(srsf_pkg::MODE_LAUNCH) &&
      res_q.stop_arg == srsf_pkg::STOP_LINE)
    else $error("stop request did not return to launch");

  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // Each accepted request yields a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // Speeds only with the both-speeds action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.drive_action != srsf_pkg::ACT_BOTH |->
      res_q.left_speed == 8'sd0 && res_q.right_speed == 8'sd0)
    else $error("speeds set outside both-speeds action");

  // Stop argument is one of the two stop kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.drive_action == srsf_pkg::ACT_STOP |->
      res_q.stop_arg == srsf_pkg::STOP_LINE || res_q.stop_arg == srsf_pkg::STOP_TURN)
    else $error("bad stop argument");
`endif

endmodule

@@ src/srsf_step.sv @@
// Next-mode and motor-command logic for one sensor tick.
module srsf_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  cmd_i,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic [6:0]            enemy_i,
  input  logic [1:0]            line_i,
  input  srsf_pkg::mode_e       mode_i,
  input  srsf_pkg::cfg_t        cfg_i,
  input  logic [TIME_BITS-1:0]  low_start_i,
  input  logic [TIME_BITS-1:0]  high_start_i,
  input  logic [TIME_BITS-1:0]  turn_start_i,
  input  logic [TIME_BITS-1:0]  pivot_start_i,
  input  logic [TIME_BITS-1:0]  rev_start_i,
  output srsf_pkg::mode_e       mode_o,
  output srsf_pkg::stamp_ld_t   ld_o,
  output srsf_pkg::res_t        res_o
);

  logic [TIME_BITS-1:0] el_low, el_high, el_turn, el_pivot, el_rev;
  logic                 line_any, tail_en;
  logic [15:0]          el16;
  logic [19:0]          el_x10, half_x7;
  logic                 turn_done, turning;
  srsf_pkg::mode_e      mode_n;

  // Wrapping elapsed times.
  assign el_low   = now_i - low_start_i;
  assign el_high  = now_i - high_start_i;
  assign el_turn  = now_i - turn_start_i;
  assign el_pivot = now_i - pivot_start_i;
  assign el_rev   = now_i - rev_start_i;

  assign line_any = |line_i;

  // Fractions of the half turn: 0.7 as 10*e < 7*h, 0.5 as 2*e < h.
  // Only looked at while e < h, so the low 16 bits of e suffice.
  assign turn_done = el_turn >= TIME_BITS'(cfg_i.half_turn_ms);
  assign el16      = el_turn[15:0];
  assign el_x10    = 20'(el16) * 20'd10;
  assign half_x7   = 20'(cfg_i.half_turn_ms) * 20'd7;

  always_comb begin
    turning = 1'b0;
    if (!turn_done) begin
      if (mode_i == srsf_pkg::MODE_RIGHT180) begin
        turning = el_x10 < half_x7;
      end else begin
        turning = {1'b0, el16, 1'b0} < {2'b00, cfg_i.half_turn_ms};
      end
    end
  end

  always_comb begin
    mode_n  = mode_i;
    ld_o    = '0;
    res_o   = '0;
    tail_en = 1'b0;
    res_o.drive_action = srsf_pkg::ACT_NONE;

    if (cmd_i) begin
      mode_n             = srsf_pkg::MODE_LAUNCH;
      res_o.drive_action = srsf_pkg::ACT_STOP;
      res_o.stop_arg     = srsf_pkg::STOP_LINE;
    end else begin
      unique case (mode_i)
        srsf_pkg::MODE_LAUNCH: begin
          res_o.drive_action = srsf_pkg::ACT_BOTH;
          res_o.left_speed   = cfg_i.power_set_b[39:32];
          res_o.right_speed  = cfg_i.power_set_b[39:32];
          res_o.hold_ms      = cfg_i.launch_ms;
          mode_n             = srsf_pkg::MODE_START;
        end
        srsf_pkg::MODE_START: begin
          priority if (line_any) begin
            mode_n = srsf_pkg::MODE_LINE;
          end else if (|enemy_i[5:0]) begin
            mode_n = srsf_pkg::MODE_ALIGN;
          end else if (enemy_i[6]) begin
            mode_n  = srsf_pkg::MODE_RIGHT180;
            ld_o.turn = 1'b1;
          end else begin
            mode_n = srsf_pkg::MODE_SEARCH;
          end
        end
        srsf_pkg::MODE_SEARCH: begin
          res_o.drive_action = srsf_pkg::ACT_FWD;
          res_o.drive_power  = cfg_i.power_set_a[7:0];
          mode_n             = srsf_pkg::MODE_START;
        end
        srsf_pkg::MODE_ALIGN: begin
          priority if (enemy_i[2] || enemy_i[3]) begin
            mode_n = srsf_pkg::MODE_ADVANCE;
          end else if (enemy_i[0] || enemy_i[1]) begin
            res_o.drive_action = srsf_pkg::ACT_LEFT;
            res_o.drive_power  = cfg_i.power_set_a[15:8];
          end else if (enemy_i[4] || enemy_i[5]) begin
            res_o.drive_action = srsf_pkg::ACT_RIGHT;
            res_o.drive_power  = cfg_i.power_set_a[15:8];
          end else begin
            mode_n = srsf_pkg::MODE_START;
          end
        end
        srsf_pkg::MODE_ORBIT: begin
          res_o.drive_action = srsf_pkg::ACT_BOTH;
          res_o.left_speed   = srsf_pkg::ORBIT_LS;
          res_o.right_speed  = srsf_pkg::ORBIT_RS;
        end
        srsf_pkg::MODE_ADVANCE: begin
          if (enemy_i[2] || enemy_i[3]) begin
            res_o.drive_action = srsf_pkg::ACT_FWD;
            res_o.drive_power  = cfg_i.power_set_a[23:16];
            if (enemy_i[2] && enemy_i[3]) begin
              mode_n   = srsf_pkg::MODE_LOW;
              ld_o.low = 1'b1;
            end
          end else begin
            mode_n = srsf_pkg::MODE_ALIGN;
          end
        end
        srsf_pkg::MODE_LOW: begin
          tail_en = 1'b1;
          if (el_low < TIME_BITS'(cfg_i.low_attack_ms)) begin
            res_o.drive_action = srsf_pkg::ACT_FWD;
            res_o.drive_power  = cfg_i.power_set_a[31:24];
          end else begin
            mode_n    = srsf_pkg::MODE_HIGH;
            ld_o.high = 1'b1;
          end
        end
        srsf_pkg::MODE_HIGH: begin
          tail_en = 1'b1;
          if (el_high < TIME_BITS'(cfg_i.high_attack_ms)) begin
            res_o.drive_action = srsf_pkg::ACT_FWD;
            res_o.drive_power  = cfg_i.power_set_b[7:0];
          end else begin
            mode_n     = srsf_pkg::MODE_PIVOT;
            ld_o.pivot = 1'b1;
          end
        end
        srsf_pkg::MODE_LINE: begin
          res_o.drive_action = srsf_pkg::ACT_STOP;
          res_o.stop_arg     = srsf_pkg::STOP_LINE;
          ld_o.rev           = 1'b1;
          mode_n             = srsf_pkg::MODE_REVERSE;
        end
        srsf_pkg::MODE_REVERSE: begin
          priority if (el_rev < TIME_BITS'(cfg_i.reverse_ms)) begin
            res_o.drive_action = srsf_pkg::ACT_BACK;
            res_o.drive_power  = cfg_i.power_set_b[15:8];
          end else if (line_i[0]) begin
            ld_o.turn = 1'b1;
            mode_n    = srsf_pkg::MODE_RIGHT180;
          end else if (line_i[1]) begin
            ld_o.turn = 1'b1;
            mode_n    = srsf_pkg::MODE_LEFT180;
          end else begin
            mode_n = srsf_pkg::MODE_START;
          end
        end
        srsf_pkg::MODE_PIVOT: begin
          if (el_pivot < TIME_BITS'(cfg_i.attack_pivot_ms)) begin
            res_o.drive_action = srsf_pkg::ACT_PIVOT;
            res_o.drive_power  = cfg_i.power_set_b[23:16];
          end else begin
            mode_n = srsf_pkg::MODE_LOW;
          end
        end
        srsf_pkg::MODE_RIGHT180, srsf_pkg::MODE_LEFT180: begin
          if (turning) begin
            res_o.drive_action = (mode_i == srsf_pkg::MODE_RIGHT180) ?
                                 srsf_pkg::ACT_RIGHT : srsf_pkg::ACT_LEFT;
            res_o.drive_power  = cfg_i.power_set_b[31:24];
          end else begin
            res_o.drive_action = srsf_pkg::ACT_STOP;
            res_o.stop_arg     = srsf_pkg::STOP_TURN;
            if (turn_done) begin
              mode_n = srsf_pkg::MODE_START;
            end
          end
        end
        default: begin
          mode_n = srsf_pkg::MODE_LAUNCH;
        end
      endcase
    end

    // Shared attack checks; losing either front sensor wins over all of them,
    // but stamps chosen on the way are still taken.
    if (tail_en) begin
      priority if (line_any) begin
        mode_n   = srsf_pkg::MODE_LINE;
        ld_o.rev = 1'b1;
      end else if (!enemy_i[2] && !enemy_i[3] &&
                   (enemy_i[0] || enemy_i[1] || enemy_i[4] || enemy_i[5])) begin
        mode_n = srsf_pkg::MODE_ALIGN;
      end else if (enemy_i[6]) begin
        mode_n    = srsf_pkg::MODE_RIGHT180;
        ld_o.turn = 1'b1;
      end else begin
        mode_n = mode_n;
      end
      if (!(enemy_i[2] && enemy_i[3])) begin
        mode_n = srsf_pkg::MODE_START;
      end
    end

    res_o.mode_now = srsf_pkg::mode_code(mode_n);
  end

  assign mode_o = mode_n;

endmodule

@@ tb/sv/sumo_strategy_checker.sv @@
// Checker for the sumo strategy machine: predicts each motor command and compares.
`timescale 1ns / 100ps

module sumo_strategy_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [31:0] now_ms, [38:32] enemy_sensors, [40:39] line_sensors, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] mode_now, [6:4] drive_action, [14:7] drive_power, [22:15] left_speed,
  // [30:23] right_speed, [38:31] stop_arg, [54:39] hold_ms, [55] zero
  input  logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  output int          errors_o,
  output int          outstanding_o
);

  typedef enum logic [3:0] {
    ST_LAUNCH   = 4'd0,
    ST_START    = 4'd1,
    ST_SEARCH   = 4'd2,
    ST_ALIGN    = 4'd3,
    ST_ORBIT    = 4'd4,
    ST_ADVANCE  = 4'd5,
    ST_LOW      = 4'd6,
    ST_HIGH     = 4'd7,
    ST_LINE     = 4'd8,
    ST_REVERSE  = 4'd9,
    ST_PIVOT    = 4'd10,
    ST_RIGHT180 = 4'd11,
    ST_LEFT180  = 4'd12
  } strat_e;

  strat_e         st;
  logic [31:0]    low_t0, high_t0, turn_t0, pivot_t0, rev_t0;
  srsf_pkg::cfg_t regs;
  srsf_pkg::res_t expected_cmds[$];
  srsf_pkg::res_t want;
  int             errors = 0;

  assign errors_o = errors;

  task automatic check_field(input string what, input longint unsigned exp_v,
                             input longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  // Shared exit checks of both attack modes; losing the front pair wins last.
  function automatic void attack_exit(logic [31:0] now, logic hit, logic [6:0] e);
    if (hit) begin
      st     = ST_LINE;
      rev_t0 = now;
    end else if (!e[2] && !e[3] && (e[0] || e[1] || e[4] || e[5])) begin
      st = ST_ALIGN;
    end else if (e[6]) begin
      st      = ST_RIGHT180;
      turn_t0 = now;
    end
    if (!(e[2] && e[3])) begin
      st = ST_START;
    end
  endfunction

  function automatic srsf_pkg::res_t predict_command(logic cmd, logic [31:0] now,
                                                     logic [6:0] e, logic [1:0] ln);
    srsf_pkg::res_t r;
    logic [31:0]    el;
    logic           hit;
    logic           turning;
    hit            = |ln;
    r              = '0;
    r.drive_action = srsf_pkg::ACT_NONE;
    if (cmd) begin
      st             = ST_LAUNCH;
      r.drive_action = srsf_pkg::ACT_STOP;
      r.stop_arg     = srsf_pkg::STOP_LINE;
      r.mode_now     = st;
      return r;
    end
    case (st)
      ST_LAUNCH: begin
        r.drive_action = srsf_pkg::ACT_BOTH;
        r.left_speed   = regs.power_set_b[39:32];
        r.right_speed  = regs.power_set_b[39:32];
        r.hold_ms      = regs.launch_ms;
        st             = ST_START;
      end
      ST_START: begin
        if (hit) begin
          st = ST_LINE;
        end else if (|e[5:0]) begin
          st = ST_ALIGN;
        end else if (e[6]) begin
          st      = ST_RIGHT180;
          turn_t0 = now;
        end else begin
          st = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        r.drive_action = srsf_pkg::ACT_FWD;
        r.drive_power  = regs.power_set_a[7:0];
        st             = ST_START;
      end
      ST_ALIGN: begin
        if (e[2] || e[3]) begin
          st = ST_ADVANCE;
        end else if (e[0] || e[1]) begin
          r.drive_action = srsf_pkg::ACT_LEFT;
          r.drive_power  = regs.power_set_a[15:8];
        end else if (e[4] || e[5]) begin
          r.drive_action = srsf_pkg::ACT_RIGHT;
          r.drive_power  = regs.power_set_a[15:8];
        end else begin
          st = ST_START;
        end
      end
      ST_ORBIT: begin
        r.drive_action = srsf_pkg::ACT_BOTH;
        r.left_speed   = srsf_pkg::ORBIT_LS;
        r.right_speed  = srsf_pkg::ORBIT_RS;
      end
      ST_ADVANCE: begin
        if (e[2] || e[3]) begin
          r.drive_action = srsf_pkg::ACT_FWD;
          r.drive_power  = regs.power_set_a[23:16];
          if (e[2] && e[3]) begin
            st     = ST_LOW;
            low_t0 = now;
          end
        end else begin
          st = ST_ALIGN;
        end
      end
      ST_LOW: begin
        el = now - low_t0;
        if (el < {16'd0, regs.low_attack_ms}) begin
          r.drive_action = srsf_pkg::ACT_FWD;
          r.drive_power  = regs.power_set_a[31:24];
        end else begin
          st      = ST_HIGH;
          high_t0 = now;
        end
        attack_exit(now, hit, e);
      end
      ST_HIGH: begin
        el = now - high_t0;
        if (el < {16'd0, regs.high_attack_ms}) begin
          r.drive_action = srsf_pkg::ACT_FWD;
          r.drive_power  = regs.power_set_b[7:0];
        end else begin
          pivot_t0 = now;
          st       = ST_PIVOT;
        end
        attack_exit(now, hit, e);
      end
      ST_LINE: begin
        r.drive_action = srsf_pkg::ACT_STOP;
        r.stop_arg     = srsf_pkg::STOP_LINE;
        rev_t0         = now;
        st             = ST_REVERSE;
      end
      ST_REVERSE: begin
        el = now - rev_t0;
        if (el < {16'd0, regs.reverse_ms}) begin
          r.drive_action = srsf_pkg::ACT_BACK;
          r.drive_power  = regs.power_set_b[15:8];
        end else if (ln[0]) begin
          turn_t0 = now;
          st      = ST_RIGHT180;
        end else if (ln[1]) begin
          turn_t0 = now;
          st      = ST_LEFT180;
        end else begin
          st = ST_START;
        end
      end
      ST_PIVOT: begin
        el = now - pivot_t0;
        if (el < {16'd0, regs.attack_pivot_ms}) begin
          r.drive_action = srsf_pkg::ACT_PIVOT;
          r.drive_power  = regs.power_set_b[23:16];
        end else begin
          st = ST_LOW;
        end
      end
      ST_RIGHT180, ST_LEFT180: begin
        el = now - turn_t0;
        // 0.7 and 0.5 of the turn time as exact integer compares
        if (el >= {16'd0, regs.half_turn_ms}) begin
          turning = 1'b0;
        end else if (st == ST_RIGHT180) begin
          turning = ({32'd0, el} * 64'd10) < ({48'd0, regs.half_turn_ms} * 64'd7);
        end else begin
          turning = ({32'd0, el} * 64'd2) < {48'd0, regs.half_turn_ms};
        end
        if (turning) begin
          if (st == ST_RIGHT180) begin
            r.drive_action = srsf_pkg::ACT_RIGHT;
          end else begin
            r.drive_action = srsf_pkg::ACT_LEFT;
          end
          r.drive_power = regs.power_set_b[31:24];
        end else begin
          r.drive_action = srsf_pkg::ACT_STOP;
          r.stop_arg     = srsf_pkg::STOP_TURN;
          if (el >= {16'd0, regs.half_turn_ms}) begin
            st = ST_START;
          end
        end
      end
      default: st = ST_LAUNCH;
    endcase
    r.mode_now = st;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st                   = ST_LAUNCH;
      low_t0               = '0;
      high_t0              = '0;
      turn_t0              = '0;
      pivot_t0             = '0;
      rev_t0               = '0;
      regs.launch_ms       = 16'd200;
      regs.low_attack_ms   = 16'd300;
      regs.high_attack_ms  = 16'd300;
      regs.reverse_ms      = 16'd300;
      regs.attack_pivot_ms = 16'd150;
      regs.half_turn_ms    = 16'd400;
      regs.power_set_a     = '0;
      regs.power_set_b     = '0;
      expected_cmds.delete();
      outstanding_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: result 0x%0h with no request pending", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("mode_now", want.mode_now, m_axis_tdata[3:0]);
          check_field("drive_action", want.drive_action, m_axis_tdata[6:4]);
          check_field("drive_power", want.drive_power, m_axis_tdata[14:7]);
          check_field("left_speed", {56'd0, want.left_speed}, m_axis_tdata[22:15]);
          check_field("right_speed", {56'd0, want.right_speed}, m_axis_tdata[30:23]);
          check_field("stop_arg", want.stop_arg, m_axis_tdata[38:31]);
          check_field("hold_ms", want.hold_ms, m_axis_tdata[54:39]);
          check_field("pad bit", 0, m_axis_tdata[55]);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srsf_pkg::REG_LAUNCH_MS:  regs.launch_ms       = cfg_data_i[15:0];
          srsf_pkg::REG_LOW_MS:     regs.low_attack_ms   = cfg_data_i[15:0];
          srsf_pkg::REG_HIGH_MS:    regs.high_attack_ms  = cfg_data_i[15:0];
          srsf_pkg::REG_REVERSE_MS: regs.reverse_ms      = cfg_data_i[15:0];
          srsf_pkg::REG_PIVOT_MS:   regs.attack_pivot_ms = cfg_data_i[15:0];
          srsf_pkg::REG_HALF_TURN:  regs.half_turn_ms    = cfg_data_i[15:0];
          srsf_pkg::REG_POWER_A:    regs.power_set_a     = cfg_data_i[31:0];
          srsf_pkg::REG_POWER_B:    regs.power_set_b     = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(predict_command(s_axis_tuser, s_axis_tdata[31:0],
                                                s_axis_tdata[38:32], s_axis_tdata[40:39]));
      end
      outstanding_o <= expected_cmds.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the sumo strategy testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

  // Sensor patterns: the two front sensors, the side sensors and the rear one.
  localparam logic [6:0] FRONT = 7'b000_1100;
  localparam logic [6:0] SIDES = 7'b011_0011;
  localparam logic [6:0] REAR  = 7'b100_0000;

  localparam int PHASE_ITEMS = 255;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {SET_SHORT, SET_ZERO, SET_MAX, SET_WIDE, SET_MIXED} set_kind_e;
  typedef enum int {RX_STEADY, RX_COIN, RX_MOSTLY, RX_SLOW} rx_style_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [srsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [srsf_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  int failures;
  int pending_results;

  // Stimulus bookkeeping
  srsf_pkg::cfg_t cur;            // settings currently loaded, used to pace time
  logic [31:0]    clock_ms = '0;  // running time stamp of the random part
  int             step_max = 1;   // largest time step between two ticks
  int             burst_left = 20;
  int             sent = 0;       // requests accepted so far
  int             hold_reqs = 0;  // long receiver hold-offs asked for
  int             holds_done = 0;

  set_kind_e phase_kind [6] = '{SET_SHORT, SET_ZERO, SET_MAX, SET_WIDE, SET_MIXED, SET_SHORT};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sumo_robot_strategy_fsm_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  sumo_strategy_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (failures),
    .outstanding_o (pending_results)
  );

  // Offer one request and hold it until taken. Between bursts tvalid drops
  // for a random gap; the gap is never empty, so tvalid always goes low.
  task automatic send_tick(input logic cmd, input logic [31:0] now, input logic [6:0] enemy,
                           input logic [1:0] line);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, line, enemy, now};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 120);   // a long stretch without gaps
      end else begin
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Advance the time stamp, now and then with a jump anywhere in the range.
  task automatic tick(input logic cmd, input logic [6:0] enemy, input logic [1:0] line);
    if ($urandom_range(0, 59) == 0) begin
      clock_ms = $urandom;
    end else begin
      clock_ms += $urandom_range(0, step_max);
    end
    send_tick(cmd, clock_ms, enemy, line);
  endtask

  // Time step scaled to a duration so that phases end within a few ticks.
  function automatic int pace_for(logic [15:0] span);
    int base;
    base = (span > 16'd3000) ? 3000 : int'(span);
    if ($urandom_range(0, 9) == 0) begin
      return 0;
    end
    return base / $urandom_range(1, 8) + 1;
  endfunction

  // All eight registers, with junk above the width of the narrow ones.
  task automatic write_settings(input srsf_pkg::cfg_t c);
    logic [39:0] val [8];
    val[srsf_pkg::REG_LAUNCH_MS]  = {24'($urandom), c.launch_ms};
    val[srsf_pkg::REG_LOW_MS]     = {24'($urandom), c.low_attack_ms};
    val[srsf_pkg::REG_HIGH_MS]    = {24'($urandom), c.high_attack_ms};
    val[srsf_pkg::REG_REVERSE_MS] = {24'($urandom), c.reverse_ms};
    val[srsf_pkg::REG_PIVOT_MS]   = {24'($urandom), c.attack_pivot_ms};
    val[srsf_pkg::REG_HALF_TURN]  = {24'($urandom), c.half_turn_ms};
    val[srsf_pkg::REG_POWER_A]    = {8'($urandom), c.power_set_a};
    val[srsf_pkg::REG_POWER_B]    = c.power_set_b;
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= k[srsf_pkg::CFG_IDX_W-1:0];
      cfg_data_i <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Sender pauses until every expected command has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Random part of one phase: mostly well-formed engagements with random
  // detail, the rest noise and stop commands.
  task automatic run_phase(input int count);
    int          target;
    int          len;
    int          pick;
    logic [6:0]  e;
    logic [1:0]  ln;
    target = sent + count;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Front contact: start, align, advance, low and high attack, pivot.
        case ($urandom_range(0, 2))
          0: step_max = pace_for(cur.low_attack_ms);
          1: step_max = pace_for(cur.high_attack_ms);
          default: step_max = pace_for(cur.attack_pivot_ms);
        endcase
        len = $urandom_range(4, 40);
        for (int k = 0; k < len; k++) begin
          e  = FRONT;
          ln = 2'b00;
          if ($urandom_range(0, 3) == 0) begin
            e |= 7'($urandom) & ~FRONT;
          end
          if (k == len - 1) begin
            case ($urandom_range(0, 3))
              0: ln = 2'($urandom_range(1, 3));        // edge line during attack
              1: e  = 7'($urandom) & ~7'b000_1000;     // lose the front pair
              2: e |= REAR;
              default: ;
            endcase
          end
          tick(1'b0, e, ln);
        end
      end else if (pick < 55) begin
        // Edge line: stop, back away, then a half turn away from the line.
        step_max = ($urandom_range(0, 1) == 0) ? pace_for(cur.reverse_ms)
                                                : pace_for(cur.half_turn_ms);
        len = $urandom_range(4, 25);
        ln  = 2'($urandom_range(1, 3));
        for (int k = 0; k < len; k++) begin
          e = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'd0;
          if ($urandom_range(0, 3) == 0) begin
            tick(1'b0, e, 2'($urandom_range(0, 3)));
          end else begin
            tick(1'b0, e, ln);
          end
        end
      end else if (pick < 65) begin
        // Opponent behind: right half turn run to completion.
        step_max = pace_for(cur.half_turn_ms);
        tick(1'b0, REAR, 2'b00);
        len = $urandom_range(3, 20);
        for (int k = 0; k < len; k++) begin
          tick(1'b0, 7'd0, 2'b00);
        end
      end else if (pick < 75) begin
        // Opponent to one side: aligning turns, maybe ending on the front.
        len = $urandom_range(2, 8);
        for (int k = 0; k < len; k++) begin
          e = 7'($urandom) & SIDES;
          if (e == 7'd0) begin
            e = 7'b000_0001;
          end
          tick(1'b0, e, 2'b00);
        end
        if ($urandom_range(0, 1) == 0) begin
          tick(1'b0, FRONT, 2'b00);
        end
      end else if (pick < 85) begin
        // Nothing seen: search.
        len = $urandom_range(2, 6);
        for (int k = 0; k < len; k++) begin
          tick(1'b0, 7'd0, 2'b00);
        end
      end else if (pick < 95) begin
        len = $urandom_range(1, 10);
        step_max = $urandom_range(0, 2000);
        for (int k = 0; k < len; k++) begin
          tick(($urandom_range(0, 7) == 0), 7'($urandom), 2'($urandom));
        end
      end else begin
        // Stop and return to launch.
        tick(1'b1, 7'($urandom), 2'($urandom));
      end
    end
  endtask

  // Receiver: stall patterns of its own, plus long hold-offs on request.
  initial begin : sink
    rx_style_e style;
    int        run;
    @(posedge rst_ni);
    forever begin
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        style = rx_style_e'($urandom_range(0, 3));
        run   = $urandom_range(8, 64);
        for (int k = 0; k < run; k++) begin
          case (style)
            RX_STEADY: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
            default:   m_axis_tready <= ($urandom_range(0, 9) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] d [6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: short durations and distinct power bytes so that every
    // drive is easy to tell apart.
    cur.launch_ms       = 16'd7;
    cur.low_attack_ms   = 16'd3;
    cur.high_attack_ms  = 16'd3;
    cur.reverse_ms      = 16'd2;
    cur.attack_pivot_ms = 16'd2;
    cur.half_turn_ms    = 16'd10;
    cur.power_set_a     = 32'h4433_2211;
    cur.power_set_b     = 40'h99_8877_6655;
    write_settings(cur);

    send_tick(1'b1, 32'd0, 7'd0, 2'b00);        // stop straight out of reset
    send_tick(1'b0, 32'd0, 7'd0, 2'b00);        // launch drive with hold
    send_tick(1'b0, 32'd1, FRONT, 2'b00);       // start -> align
    send_tick(1'b0, 32'd2, FRONT, 2'b00);       // align -> advance
    send_tick(1'b0, 32'd3, FRONT, 2'b00);       // advance, both fronts -> low attack
    send_tick(1'b0, 32'd4, FRONT, 2'b00);       // low attack drive
    send_tick(1'b0, 32'd10, FRONT, 2'b00);      // low attack over -> high
    send_tick(1'b0, 32'd11, FRONT, 2'b00);      // high attack drive
    send_tick(1'b0, 32'd20, FRONT, 2'b00);      // high attack over -> pivot
    send_tick(1'b0, 32'd21, FRONT, 2'b00);      // pivot drive
    send_tick(1'b0, 32'd30, FRONT, 2'b00);      // pivot over -> low, no drive
    send_tick(1'b0, 32'd31, 7'b000_0100, 2'b01); // line hit but front lost: back to start
    send_tick(1'b0, 32'd32, REAR, 2'b00);       // start -> right half turn
    send_tick(1'b0, 32'd33, 7'd0, 2'b00);       // turning right
    send_tick(1'b0, 32'd40, 7'd0, 2'b00);       // past 0.7 of the turn: settle stop
    send_tick(1'b0, 32'd45, 7'd0, 2'b00);       // turn done -> start
    send_tick(1'b0, 32'd46, 7'd0, 2'b01);       // start, line -> line reaction
    send_tick(1'b0, 32'd47, 7'd0, 2'b01);       // line stop -> reverse
    send_tick(1'b0, 32'd48, 7'd0, 2'b10);       // backing away
    send_tick(1'b0, 32'd60, 7'd0, 2'b10);       // right line -> left half turn
    send_tick(1'b0, 32'd64, 7'd0, 2'b00);       // turning left
    send_tick(1'b0, 32'd66, 7'd0, 2'b00);       // past half of the turn: settle stop
    send_tick(1'b0, 32'hFFFF_FFFF, 7'h7F, 2'b11); // all ones, turn done
    send_tick(1'b0, 32'd5, 7'd0, 2'b00);        // start -> search
    send_tick(1'b0, 32'hFFFF_FFF0, 7'd0, 2'b00); // search drive
    drain();

    for (int p = 0; p < 6; p++) begin
      // New register setting for this phase, extremes included.
      for (int k = 0; k < 6; k++) begin
        case (phase_kind[p])
          SET_SHORT: d[k] = 16'($urandom_range(1, 40));
          SET_ZERO:  d[k] = '0;
          SET_MAX:   d[k] = '1;
          SET_WIDE:  d[k] = 16'($urandom);
          default: begin
            case ($urandom_range(0, 2))
              0: d[k] = '0;
              1: d[k] = '1;
              default: d[k] = 16'($urandom_range(1, 60));
            endcase
          end
        endcase
      end
      cur.launch_ms       = d[0];
      cur.low_attack_ms   = d[1];
      cur.high_attack_ms  = d[2];
      cur.reverse_ms      = d[3];
      cur.attack_pivot_ms = d[4];
      cur.half_turn_ms    = d[5];
      if (phase_kind[p] == SET_ZERO) begin
        cur.power_set_a = '0;
        cur.power_set_b = '0;
      end else if (phase_kind[p] == SET_MAX) begin
        cur.power_set_a = '1;
        cur.power_set_b = '1;
      end else begin
        cur.power_set_a = $urandom;
        cur.power_set_b = {8'($urandom), 32'($urandom)};
      end
      write_settings(cur);

      // Start some phases just below the wrap of the time stamp.
      if ($urandom_range(0, 1) == 0) begin
        clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
      end

      // Receiver holds off while the sender keeps offering, so the block
      // fills up and stalls its request side.
      hold_reqs++;
      burst_left = 400;
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
